>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock outside reset
`define LEB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define LEB_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define LEB_ASSERT(lbl, clk, rstn, prop)
`define LEB_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> hdl/leb_pkg.sv
// ---------------------------------------------------------------------------
// leb_pkg
// shared types and constants of the line edit buffer
// ---------------------------------------------------------------------------
package leb_pkg;

  localparam int CHAR_W         = 8;
  localparam int CFG_IDX_W      = 8;
  localparam int LINE_DEPTH_DEF = 63;
  localparam int CMDQ_DEPTH     = 2;
  localparam int OUTQ_DEPTH     = 2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] ERASE_RESET  = 8'd35;
  localparam logic [CHAR_W-1:0] KILL_RESET   = 8'd64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ERASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_KILL  = 8'd1;

  // command opcodes from front to back
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_ERASE   = 3'd1;
  localparam logic [OP_W-1:0] OP_KILL    = 3'd2;
  localparam logic [OP_W-1:0] OP_NEWLINE = 3'd3;
  localparam logic [OP_W-1:0] OP_EOT     = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage

>>> hdl/line_edit_buffer_core.sv
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// line_edit_buffer_core
// line editor with erase and kill codes, emits whole lines oldest first
// ---------------------------------------------------------------------------
// The front takes one word per cycle into a two-entry command queue and
// reports full when it fills. Append, erase and kill commands are handled
// in the back's idle state, so typing runs at one word per cycle while no
// line drains. A newline or end of text drains each stored character
// through a read and a push state, as the line store has one registered
// read port, and a newline adds a newline word. Results leave through a
// two-entry output queue. No clearing pass is needed after reset.
module line_edit_buffer_core import leb_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic                 in_end_of_text,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [CHAR_W-1:0]    out_char,
  output logic                 out_last_of_line,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHAR_W-1:0]    cfg_data
);

  localparam int FILL_W = $clog2(LINE_DEPTH + 1);

  cmd_t              cmd_in, cmd_out;
  fifo_st_t          cmd_st, out_st;
  logic              cmd_push, cmd_pop;
  logic              out_push;
  out_t              out_in, out_head;
  logic [FILL_W-1:0] bk_fill;

  // front: config and classification
  leb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_st         (cmd_st),
    .cmd_push       (cmd_push),
    .cmd_word       (cmd_in)
  );

  // command queue between front and back
  leb_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMDQ_DEPTH)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .st    (cmd_st)
  );

  // back: line store and drain sequencer
  leb_back #(.LINE_DEPTH(LINE_DEPTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_word (cmd_out),
    .cmd_st   (cmd_st),
    .cmd_pop  (cmd_pop),
    .outq_st  (out_st),
    .out_push (out_push),
    .out_word (out_in),
    .fill     (bk_fill)
  );

  // result queue
  leb_fifo #(.WIDTH($bits(out_t)), .DEPTH(OUTQ_DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_in),
    .pop   (out_pop),
    .rdata (out_head),
    .st    (out_st)
  );

  assign out_empty        = out_st.empty;
  assign out_char         = out_head.ch;
  assign out_last_of_line = out_head.last;

  // checks
  `LEB_ASSERT_NEVER(a_outq_overflow, clk, rst_n, out_push && out_st.full)
  `LEB_ASSERT_NEVER(a_cmdq_underflow, clk, rst_n, cmd_pop && cmd_st.empty)
  `LEB_ASSERT(a_fill_bound, clk, rst_n, bk_fill <= FILL_W'(LINE_DEPTH))
  `LEB_ASSERT(a_accept_queued, clk, rst_n, (in_push && !in_full) |=> !cmd_st.empty)

endmodule

>>> hdl/leb_fifo.sv
// ---------------------------------------------------------------------------
// leb_fifo
// small register queue used for the command and the result words
// ---------------------------------------------------------------------------
module leb_fifo import leb_pkg::*; #(
  parameter int WIDTH = CHAR_W,
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output fifo_st_t         st
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign st.full  = (cnt_r == CW'(DEPTH));
  assign st.empty = (cnt_r == '0);
  assign do_push  = push && !st.full;
  assign do_pop   = pop && !st.empty;
  assign rdata    = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = do_push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt = do_pop ? ptr_inc(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

>>> hdl/leb_front.sv
// ---------------------------------------------------------------------------
// leb_front
// holds the erase and kill codes and turns each input word into a command
// ---------------------------------------------------------------------------
module leb_front import leb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic                 in_end_of_text,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHAR_W-1:0]    cfg_data,
  input  fifo_st_t             cmd_st,
  output logic                 cmd_push,
  output cmd_t                 cmd_word
);

  logic [CHAR_W-1:0] erase_r, erase_nxt;
  logic [CHAR_W-1:0] kill_r, kill_nxt;

  assign cfg_ready = 1'b1;
  assign in_full   = cmd_st.full;
  assign cmd_push  = in_push && !cmd_st.full;

  // register write decode
  always_comb begin
    erase_nxt = erase_r;
    kill_nxt  = kill_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_ERASE: erase_nxt = cfg_data;
        CFG_IDX_KILL:  kill_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_r <= ERASE_RESET;
      kill_r  <= KILL_RESET;
    end else begin
      erase_r <= erase_nxt;
      kill_r  <= kill_nxt;
    end
  end

  // classify: end of text, newline, erase, kill, then plain character
  always_comb begin
    cmd_word.ch = in_char_code;
    if (in_end_of_text) begin
      cmd_word.op = OP_EOT;
    end else if (in_char_code == NEWLINE_CODE) begin
      cmd_word.op = OP_NEWLINE;
    end else if (in_char_code == erase_r) begin
      cmd_word.op = OP_ERASE;
    end else if (in_char_code == kill_r) begin
      cmd_word.op = OP_KILL;
    end else begin
      cmd_word.op = OP_APPEND;
    end
  end

endmodule

>>> hdl/leb_back.sv
// ---------------------------------------------------------------------------
// leb_back
// executes commands on the line store and drains finished lines
// ---------------------------------------------------------------------------
module leb_back import leb_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cmd_t                               cmd_word,
  input  fifo_st_t                           cmd_st,
  output logic                               cmd_pop,
  input  fifo_st_t                           outq_st,
  output logic                               out_push,
  output out_t                               out_word,
  output logic [$clog2(LINE_DEPTH + 1)-1:0]  fill
);

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW = $clog2(LINE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam logic [1:0] ST_NL   = 2'd3;

  logic [CHAR_W-1:0] store_mem [LINE_DEPTH];
  logic [CHAR_W-1:0] rd_data_r;
  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              nl_r, nl_nxt;
  logic              mem_we;
  logic              last_idx;

  assign fill     = fill_r;
  assign last_idx = ((CW'(idx_r) + CW'(1)) == fill_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    nl_nxt    = nl_r;
    mem_we    = 1'b0;
    cmd_pop   = 1'b0;
    out_push  = 1'b0;
    out_word  = '{ch: rd_data_r, last: last_idx && !nl_r};
    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_st.empty) begin
          cmd_pop = 1'b1;
          unique case (cmd_word.op)
            OP_APPEND: begin
              if (fill_r < CW'(LINE_DEPTH)) begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + CW'(1);
              end
            end
            OP_ERASE: begin
              if (fill_r != '0) begin
                fill_nxt = fill_r - CW'(1);
              end
            end
            OP_KILL: fill_nxt = '0;
            OP_NEWLINE: begin
              nl_nxt  = 1'b1;
              idx_nxt = '0;
              state_nxt = (fill_r == '0) ? ST_NL : ST_READ;
            end
            OP_EOT: begin
              nl_nxt  = 1'b0;
              idx_nxt = '0;
              if (fill_r != '0) begin
                state_nxt = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (!outq_st.full) begin
          out_push = 1'b1;
          if (last_idx) begin
            if (nl_r) begin
              state_nxt = ST_NL;
            end else begin
              fill_nxt  = '0;
              state_nxt = ST_IDLE;
            end
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_READ;
          end
        end
      end
      ST_NL: begin
        out_word = '{ch: NEWLINE_CODE, last: 1'b1};
        if (!outq_st.full) begin
          out_push  = 1'b1;
          fill_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      idx_r   <= '0;
      nl_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      nl_r    <= nl_nxt;
    end
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[fill_r[AW-1:0]] <= cmd_word.ch;
    end
    rd_data_r <= store_mem[idx_r];
  end

endmodule
